FILE: hw/rtl/drds_pkg.sv
// Shared types and constants for the dense-rank descending sorter.
package drds_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int SCORE_BITS_DEF = 32;
    localparam int ROW_IDX_W      = 6;
    localparam int RANK_W         = 7;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } drds_state_t;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic insert;   // place the arriving row
        logic shift;    // move every row one cell toward the head
    } drds_ctrl_t;

endpackage

FILE: hw/rtl/drds_cell.sv
// One cell of the insertion chain: holds one row, compares, takes from a neighbor.
module drds_cell #(
    parameter int SCORE_BITS = drds_pkg::SCORE_BITS_DEF
) (
    input  logic                           aclk,
    input  drds_pkg::drds_ctrl_t           ctrl,
    input  logic                           occupied,
    input  logic [SCORE_BITS-1:0]          new_score,
    input  logic                           new_present,
    input  logic [drds_pkg::ROW_IDX_W-1:0] new_index,
    input  logic                           left_ins,
    input  logic [SCORE_BITS-1:0]          left_score,
    input  logic                           left_present,
    input  logic [drds_pkg::ROW_IDX_W-1:0] left_index,
    input  logic [SCORE_BITS-1:0]          right_score,
    input  logic                           right_present,
    input  logic [drds_pkg::ROW_IDX_W-1:0] right_index,
    output logic                           cell_ins,
    output logic [SCORE_BITS-1:0]          score,
    output logic                           present,
    output logic [drds_pkg::ROW_IDX_W-1:0] index
);

    logic [SCORE_BITS-1:0]          score_reg, score_next;
    logic                           present_reg, present_next;
    logic [drds_pkg::ROW_IDX_W-1:0] index_reg, index_next;

    // New row goes ahead of this one: the cell is empty, strictly greater present
    // score, or present against missing. Ties stay behind (arrival order).
    assign cell_ins = !occupied
                      || (new_present
                          && (!present_reg
                              || ($signed(new_score) > $signed(score_reg))));

    always_comb begin
        score_next   = score_reg;
        present_next = present_reg;
        index_next   = index_reg;
        if (ctrl.shift) begin
            score_next   = right_score;
            present_next = right_present;
            index_next   = right_index;
        end else if (ctrl.insert && cell_ins) begin
            if (left_ins) begin
                score_next   = left_score;
                present_next = left_present;
                index_next   = left_index;
            end else begin
                score_next   = new_score;
                present_next = new_present;
                index_next   = new_index;
            end
        end
    end

    always_ff @(posedge aclk) begin
        score_reg   <= score_next;
        present_reg <= present_next;
        index_reg   <= index_next;
    end

    assign score   = score_reg;
    assign present = present_reg;
    assign index   = index_reg;

endmodule

FILE: hw/rtl/dense_rank_descending_sorter.sv
// Top level of the dense-rank descending sorter: cell chain, sequencer, result register.
//
// Usage: rows stream in on the s_ channel, one word each: score in s_tdata,
// its present flag in s_tuser, and s_tlast on the final row of the set.
// Each accepted row is placed into a sorted chain of MAX_ROWS cells in the
// same cycle, so loading runs at one row per cycle. Rows past MAX_ROWS are
// dropped and the set is marked as overflowed.
// The word carrying s_tlast starts the emit phase. Once the sequencer is in
// it, the first result is loaded from the chain head into the output register,
// then one result per cycle while the receiver takes them: the chain shifts
// one cell toward its head for each result. s_tready is low for the whole
// emit phase; it rises again once the final result is in the output register,
// so the next set can load while that result waits.
// Results come out in descending score order, ties in arrival order, missing
// scores last. dense_rank is computed on the fly from the previous result.
// A stall on m_tready holds the output register and the chain.
// Reset (aresetn low, synchronous) empties the set and the output register;
// the cell contents need no clearing since occupancy comes from the counter.
module dense_rank_descending_sorter #(
    parameter int MAX_ROWS   = drds_pkg::MAX_ROWS_DEF,
    parameter int SCORE_BITS = drds_pkg::SCORE_BITS_DEF,
    localparam int IN_DATA_W  = ((SCORE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W =
        ((drds_pkg::ROW_IDX_W + SCORE_BITS + drds_pkg::RANK_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: score
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: score_present
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: row_index, sorted_score, dense_rank
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: sorted_present, overflowed
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int IW    = drds_pkg::ROW_IDX_W;
    localparam int RW    = drds_pkg::RANK_W;

    drds_pkg::drds_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] left_reg, left_next;     // results still to load
    logic             ovf_reg, ovf_next;

    // rank tracking across the emitted rows
    logic [SCORE_BITS-1:0] prev_reg, prev_next;
    logic                  have_prev_reg, have_prev_next;
    logic [RW-1:0]         rank_reg, rank_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [IW-1:0]         o_idx_reg, o_idx_next;
    logic [SCORE_BITS-1:0] o_score_reg, o_score_next;
    logic                  o_present_reg, o_present_next;
    logic [RW-1:0]         o_rank_reg, o_rank_next;
    logic                  o_ovf_reg, o_ovf_next;
    logic                  o_last_reg, o_last_next;

    drds_pkg::drds_ctrl_t ctrl;
    logic in_fire, full, out_load;

    // chain wiring
    logic                  c_ins     [MAX_ROWS];
    logic [SCORE_BITS-1:0] c_score   [MAX_ROWS];
    logic                  c_present [MAX_ROWS];
    logic [IW-1:0]         c_index   [MAX_ROWS];

    assign full     = (cnt_reg == CNT_W'(MAX_ROWS));
    assign s_tready = (state_reg == drds_pkg::ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == drds_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_load;

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
        logic                  l_ins, l_present, r_present;
        logic [SCORE_BITS-1:0] l_score, r_score;
        logic [IW-1:0]         l_index, r_index;

        if (i == 0) begin : g_head
            assign l_ins     = 1'b0;
            assign l_score   = '0;
            assign l_present = 1'b0;
            assign l_index   = '0;
        end else begin : g_mid
            assign l_ins     = c_ins[i-1];
            assign l_score   = c_score[i-1];
            assign l_present = c_present[i-1];
            assign l_index   = c_index[i-1];
        end

        if (i == MAX_ROWS - 1) begin : g_tail
            assign r_score   = '0;
            assign r_present = 1'b0;
            assign r_index   = '0;
        end else begin : g_body
            assign r_score   = c_score[i+1];
            assign r_present = c_present[i+1];
            assign r_index   = c_index[i+1];
        end

        drds_cell #(
            .SCORE_BITS(SCORE_BITS)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .occupied     (CNT_W'(i) < cnt_reg),
            .new_score    (s_tdata[SCORE_BITS-1:0]),
            .new_present  (s_tuser),
            .new_index    (IW'(cnt_reg)),
            .left_ins     (l_ins),
            .left_score   (l_score),
            .left_present (l_present),
            .left_index   (l_index),
            .right_score  (r_score),
            .right_present(r_present),
            .right_index  (r_index),
            .cell_ins     (c_ins[i]),
            .score        (c_score[i]),
            .present      (c_present[i]),
            .index        (c_index[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= drds_pkg::ST_LOAD;
            cnt_reg       <= '0;
            left_reg      <= '0;
            ovf_reg       <= 1'b0;
            have_prev_reg <= 1'b0;
            rank_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            ovf_reg       <= ovf_next;
            have_prev_reg <= have_prev_next;
            rank_reg      <= rank_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        o_idx_reg     <= o_idx_next;
        o_score_reg   <= o_score_next;
        o_present_reg <= o_present_next;
        o_rank_reg    <= o_rank_next;
        o_ovf_reg     <= o_ovf_next;
        o_last_reg    <= o_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        ovf_next       = ovf_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        rank_next      = rank_reg;
        m_valid_next   = m_valid_reg;
        o_idx_next     = o_idx_reg;
        o_score_next   = o_score_reg;
        o_present_next = o_present_reg;
        o_rank_next    = o_rank_reg;
        o_ovf_next     = o_ovf_reg;
        o_last_next    = o_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            drds_pkg::ST_LOAD: begin
                if (in_fire) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        left_next  = full ? cnt_reg : cnt_reg + CNT_W'(1);
                        state_next = drds_pkg::ST_EMIT;
                    end
                end
            end
            drds_pkg::ST_EMIT: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    o_idx_next     = c_index[0];
                    o_present_next = c_present[0];
                    o_score_next   = c_present[0] ? c_score[0] : '0;
                    o_ovf_next     = ovf_reg;
                    o_last_next    = (left_reg == CNT_W'(1));
                    o_rank_next    = '0;
                    if (c_present[0]) begin
                        if (!have_prev_reg || (c_score[0] != prev_reg)) begin
                            rank_next   = rank_reg + RW'(1);
                            o_rank_next = rank_reg + RW'(1);
                        end else begin
                            o_rank_next = rank_reg;
                        end
                        prev_next      = c_score[0];
                        have_prev_next = 1'b1;
                    end
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1)) begin
                        // set drained: start a fresh one
                        state_next     = drds_pkg::ST_LOAD;
                        cnt_next       = '0;
                        ovf_next       = 1'b0;
                        have_prev_next = 1'b0;
                        rank_next      = '0;
                    end
                end
            end
            default: begin
                state_next = drds_pkg::ST_LOAD;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_ovf_reg, o_present_reg};
    assign m_tdata  = OUT_DATA_W'({o_rank_reg, o_score_reg, o_idx_reg});

    // Row counter never passes the chain length.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond capacity");

    // Overflow can only be flagged on a full chain.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow flagged with free cells");

    // While emitting there is always a result left to load.
    a_emit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drds_pkg::ST_EMIT) |-> (left_reg != '0))
        else $error("emit phase with nothing left");

    // A missing score carries rank zero, a present one a nonzero rank.
    a_rank_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (o_present_reg == (o_rank_reg != '0)))
        else $error("rank inconsistent with present flag");

    // Final result leaves the sequencer back in the load phase.
    a_last_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (left_reg == CNT_W'(1))) |=> (state_reg == drds_pkg::ST_LOAD))
        else $error("final result without return to load");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the dense-rank descending sorter.
//
// Sets of rows are streamed in on the s_ channel. A scoreboard keeps its own
// model of the block: it collects each set as the rows are accepted, and on the
// row marked last it sorts the set and queues the ranked results. Each word
// taken from the m_ channel is checked field by field against the oldest
// queued result.
//
// Stimulus has two parts. A short directed part covers the score extremes,
// ties, missing scores and single-row sets. A random part follows, with mostly
// small sets plus a few sets near or past capacity. Those larger sets give
// 64 distinct ranks, an overflowed set, and a dropped row that carries the
// last mark. Both channels stall at random, except for one stretch in which
// neither side stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [drds_pkg::ROW_IDX_W-1:0]      idx;
        logic [drds_pkg::SCORE_BITS_DEF-1:0] score;
        logic                                present;
        logic [drds_pkg::RANK_W-1:0]         rank;
        logic                                ovf;
        logic                                fin;
    } ranked_row_t;

    class rank_scoreboard;
        logic [drds_pkg::SCORE_BITS_DEF-1:0] set_score[$];
        logic                                set_present[$];
        logic                                set_dropped;
        ranked_row_t                         pending[$];
        int                                  errors;

        function new();
            set_dropped = 1'b0;
            errors      = 0;
        endfunction

        // Accepted input word: store the row or mark the set as overflowed.
        // When the word is marked last, rank the set and queue its results.
        function void note_row(logic [31:0] score, logic present, logic last);
            int          order[$];
            int          pos;
            int          rank;
            logic [31:0] prev;
            ranked_row_t r;
            rank = 0;
            prev = '0;
            if (set_score.size() < drds_pkg::MAX_ROWS_DEF) begin
                set_score   = {set_score, score};
                set_present = {set_present, present};
            end else begin
                set_dropped = 1'b1;
            end
            if (!last) return;
            // Stable insertion sort of present rows, descending signed score.
            for (int i = 0; i < set_score.size(); i++) begin
                if (set_present[i]) begin
                    pos = order.size();
                    for (int j = 0; j < order.size(); j++) begin
                        if ($signed(set_score[order[j]]) < $signed(set_score[i])) begin
                            pos = j;
                            break;
                        end
                    end
                    order.insert(pos, i);
                end
            end
            // Missing scores go last, in arrival order.
            for (int i = 0; i < set_score.size(); i++)
                if (!set_present[i]) order = {order, i};
            for (int k = 0; k < order.size(); k++) begin
                r.idx     = 6'(order[k]);
                r.present = set_present[order[k]];
                if (r.present) begin
                    if (rank == 0 || set_score[order[k]] != prev) begin
                        rank++;
                        prev = set_score[order[k]];
                    end
                    r.score = set_score[order[k]];
                    r.rank  = 7'(rank);
                end else begin
                    r.score = '0;
                    r.rank  = '0;
                end
                r.ovf = set_dropped;
                r.fin = (k == order.size() - 1);
                pending = {pending, r};
            end
            set_score.delete();
            set_present.delete();
            set_dropped = 1'b0;
        endfunction

        function void compare(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                $display("%0t %s: expected %h, got %h", $time, field, exp_v, got_v);
            end
        endfunction

        // Accepted output word against the oldest queued result.
        function void check_result(logic [47:0] data, logic [1:0] user, logic last);
            ranked_row_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, got %h %b %b",
                         $time, data, user, last);
                return;
            end
            e = pending.pop_front();
            compare("row_index", 32'(e.idx), 32'(data[drds_pkg::ROW_IDX_W-1:0]));
            compare("sorted_score", e.score, data[drds_pkg::ROW_IDX_W +: 32]);
            compare("dense_rank", 32'(e.rank),
                    32'(data[drds_pkg::ROW_IDX_W + 32 +: drds_pkg::RANK_W]));
            compare("sorted_present", 32'(e.present), 32'(user[0]));
            compare("overflowed", 32'(e.ovf), 32'(user[1]));
            compare("final_result", 32'(e.fin), 32'(last));
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 200000;
    localparam int ROW_TARGET  = 360;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    rank_scoreboard sb = new();
    bit             quiet = 1'b0;   // no stalls on either side while set
    int             cycles = 0;
    int             rows_sent = 0;

    dense_rank_descending_sorter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("dense_rank_descending_sorter: mismatch");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready level.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            m_tready <= aresetn && (quiet || $urandom_range(99) >= 31);
        end
    end

    // One row word; random idle cycles ahead of it, then hold until taken.
    task automatic send_row(input logic [31:0] score, input logic present,
                            input logic last);
        while (!quiet && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= score;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_row(score, present, last);
        rows_sent++;
    endtask

    // A whole set. mode 0: wide random scores, 1: heavy ties, 2: distinct and
    // all present. Missing rows carry junk scores that must read back as zero.
    task automatic send_set(input int rows, input int mode);
        logic [31:0] sc;
        logic        pr;
        for (int i = 0; i < rows; i++) begin
            sc = $urandom();
            case (mode)
                0: pr = ($urandom_range(99) < 85);
                1: begin
                    pr = ($urandom_range(99) < 60);
                    case ($urandom_range(5))
                        0: sc = 32'h8000_0000;
                        1: sc = 32'h7FFF_FFFF;
                        2: sc = 32'h0000_0000;
                        3: sc = 32'hFFFF_FFFF;
                        4: sc = 32'h0001_0000;
                        default: sc = 32'hFFFF_0000;
                    endcase
                end
                default: begin
                    pr = 1'b1;
                    sc = {6'(i) ^ 6'h2A, sc[25:0]};
                end
            endcase
            send_row(sc, pr, i == rows - 1);
        end
    endtask

    initial begin
        int rows;
        int set_no;
        set_no = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, ties at both ends, missing rows with junk scores.
        send_row(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_row(32'h8000_0000, 1'b1, 1'b0);
        send_row(32'h0000_0000, 1'b1, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_row(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_row(32'h1234_5678, 1'b0, 1'b0);
        send_row(32'h0000_0000, 1'b1, 1'b0);
        send_row(32'h8000_0000, 1'b1, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0, 1'b1);
        // Single-row sets, present and missing.
        send_row(32'h0001_8000, 1'b1, 1'b1);
        send_row(32'hDEAD_BEEF, 1'b0, 1'b1);
        // All missing, then all equal.
        send_row(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_row(32'h0000_0001, 1'b0, 1'b1);
        send_row(32'h0001_0000, 1'b1, 1'b0);
        send_row(32'h0001_0000, 1'b1, 1'b0);
        send_row(32'h0001_0000, 1'b1, 1'b0);
        send_row(32'h0001_0000, 1'b1, 1'b1);
        // Mixed order with missing rows in between.
        send_row(32'hFFFF_0000, 1'b1, 1'b0);
        send_row(32'h5555_5555, 1'b0, 1'b0);
        send_row(32'h0000_8000, 1'b1, 1'b0);
        send_row(32'hAAAA_AAAA, 1'b1, 1'b1);

        // Random part. First a full set of 64 distinct ranks, then one whose
        // marked-last row is dropped past capacity.
        while (rows_sent < ROW_TARGET) begin
            if (set_no == 0)
                send_set(64, 2);
            else if (set_no == 1)
                send_set(67, 0);
            else begin
                rows = ($urandom_range(99) < 8) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 12);
                send_set(rows, $urandom_range(2));
            end
            set_no++;
            quiet = (rows_sent >= 180 && rows_sent < 260);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dense_rank_descending_sorter: match");
        else
            $display("dense_rank_descending_sorter: mismatch");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/drds_pkg.sv
hw/rtl/drds_cell.sv
hw/rtl/dense_rank_descending_sorter.sv
tb/testbench.sv
